[sv/whc_pkg.sv]
// Shared types and constants of the watermark header correlator.
package whc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int ACT_W     = 5;
    localparam int MAXM_W    = 6;
    localparam int ACC_W     = 15;
    localparam int STEP_W    = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PATTERN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISMATCHES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOCATIONS = 2'd2;

    localparam logic [31:0]       RST_HEADER_PATTERN   = 32'h59F1_BA84;
    localparam logic [MAXM_W-1:0] RST_MAX_MISMATCHES   = 6'd5;
    localparam logic [ACT_W-1:0]  RST_ACTIVE_LOCATIONS = 5'd16;

    localparam logic [ACC_W-1:0]  CORR_INTERVAL = 15'd10000;
    localparam logic [STEP_W-1:0] STEP_LIMIT    = 14'd10000;

    localparam logic FUNC_CORR = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] corr_word;
        logic [3:0]  location;
        logic [6:0]  bit_length;
        logic [13:0] corr_offset;
    } t_in;

    typedef struct packed {
        logic [3:0] loc_index;
        logic [5:0] rank;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPD,
        ST_UPD2,
        ST_EMIT
    } t_state;

endpackage

[sv/whc_rank.sv]
// Mismatch count of a shift word against the header pattern and the resulting rank.
module whc_rank
    import whc_pkg::*;
(
    input  logic [31:0]       i_word,
    input  logic [31:0]       i_pattern,
    input  logic [MAXM_W-1:0] i_limit,
    output logic [5:0]        o_rank
);

    logic [31:0] diff_bits;
    logic [1:0]  lvl1 [16];
    logic [2:0]  lvl2 [8];
    logic [3:0]  lvl3 [4];
    logic [4:0]  lvl4 [2];
    logic [5:0]  diff;

    assign diff_bits = i_word ^ i_pattern;

    // Population count as a balanced adder tree.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            lvl1[i] = {1'b0, diff_bits[2*i]} + {1'b0, diff_bits[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
        end
        diff = {1'b0, lvl4[0]} + {1'b0, lvl4[1]};
    end

    assign o_rank = (diff < i_limit) ? (i_limit - diff) : 6'd0;

endmodule

[sv/watermark_header_correlator_unit.sv]
// Top level of the watermark header correlator: sequencer, ring memory and location state.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): a load item sets one
// location's ring length and correction step in the cycle it transfers and
// gives no result. A correlation word gives one result per active location,
// in location order, with last set on the final one.
// Output channel (o_out_valid / i_out_stall, payload o_out) is a single output
// register; while the receiver stalls, the sequencer waits at the next result.
// Configuration writes transfer on i_cfg_valid and are always taken.
// Each location passes through ring read, update and result, plus a second update
// when its correction accumulator wraps and the bit is pushed a second time, so a
// correlation word runs these steps for each active location in turn; the
// read-modify-write of the ring memory, with one read and one write port, sets this.
// The input stalls from the transfer of a correlation word until its last
// result has entered the output register.
// Reset clears the location state and loads the register defaults. The ring
// memory itself is not swept: a fill count per location marks how much of
// that location's ring has been written, and unwritten words read as zero.
module watermark_header_correlator_unit
    import whc_pkg::*;
#(
    parameter int MAX_LOCATIONS = 16,
    parameter int MAX_RING_LEN  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int LW    = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int PW    = $clog2(MAX_RING_LEN);
    localparam int RLW   = $clog2(MAX_RING_LEN + 1);
    localparam int EW    = (RLW > 7) ? RLW : 7;
    localparam int DEPTH = 2 ** (LW + PW);
    localparam int DEF_LEN = (MAX_RING_LEN < 64) ? MAX_RING_LEN : 64;

    localparam logic [RLW-1:0]   RST_LEN = RLW'(DEF_LEN);
    localparam logic [ACT_W-1:0] LOC_CNT = ACT_W'(MAX_LOCATIONS);

    // Configuration registers.
    logic [31:0]       r_hdr;
    logic [MAXM_W-1:0] r_max;
    logic [ACT_W-1:0]  r_act;

    // Per-location state.
    logic [PW-1:0]     r_pos  [MAX_LOCATIONS];
    logic [ACC_W-1:0]  r_acc  [MAX_LOCATIONS];
    logic [RLW-1:0]    r_len  [MAX_LOCATIONS];
    logic [STEP_W-1:0] r_step [MAX_LOCATIONS];
    logic [RLW-1:0]    r_fill [MAX_LOCATIONS];

    // Ring memory.
    logic [31:0]       mem [DEPTH];
    logic [31:0]       r_rd_data;

    // Sequencer.
    t_state            r_state, n_state;
    logic [ACT_W-1:0]  r_loc;
    logic [15:0]       r_word;
    logic [31:0]       r_w1;
    logic [PW-1:0]     r_prev_p;

    logic              r_out_valid;
    t_out              r_out;

    logic              in_xfer, cfg_xfer, out_free;
    logic [ACT_W-1:0]  count;
    logic              is_last;
    logic [LW-1:0]     cur;
    logic [PW-1:0]     p_cur, p_wrap;
    logic [RLW-1:0]    fill_cur, fill_new, len_cur;
    logic [ACC_W-1:0]  acc_sum;
    logic              acc_wrap;
    logic              bit_cur;
    logic [31:0]       old_word, new_word;
    logic [5:0]        rank;

    logic              mem_we;
    logic [LW+PW-1:0]  mem_wa, mem_ra;

    logic              load_ok;
    logic [LW-1:0]     load_loc;
    logic [RLW-1:0]    load_len;
    logic [STEP_W-1:0] load_step;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign count   = (r_act > LOC_CNT) ? LOC_CNT : r_act;
    assign is_last = ((r_loc + 1'b1) == count);

    // Location state of the location in work.
    assign cur      = r_loc[LW-1:0];
    assign p_cur    = r_pos[cur];
    assign fill_cur = r_fill[cur];
    assign len_cur  = r_len[cur];
    assign bit_cur  = r_word[r_loc[3:0]];
    assign p_wrap   = ((RLW'(p_cur) + 1'b1) >= len_cur) ? '0 : (p_cur + 1'b1);
    assign fill_new = (RLW'(p_cur) == fill_cur) ? (RLW'(p_cur) + 1'b1) : fill_cur;
    assign acc_sum  = r_acc[cur] + ACC_W'(r_step[cur]);
    assign acc_wrap = (acc_sum >= CORR_INTERVAL);

    // The second push of a one-word ring hits the word just written, whose
    // read came back before the write landed.
    always_comb begin
        if (r_state == ST_UPD2 && p_cur == r_prev_p) begin
            old_word = r_w1;
        end else if (RLW'(p_cur) < fill_cur) begin
            old_word = r_rd_data;
        end else begin
            old_word = '0;
        end
    end
    assign new_word = {old_word[30:0], bit_cur};

    // Load item decode.
    always_comb begin
        load_ok  = ({1'b0, i_in.location} < LOC_CNT);
        load_loc = i_in.location[LW-1:0];
        if (i_in.bit_length == 7'd0) begin
            load_len = RLW'(1);
        end else if (EW'(i_in.bit_length) > EW'(MAX_RING_LEN)) begin
            load_len = RLW'(MAX_RING_LEN);
        end else begin
            load_len = RLW'(i_in.bit_length);
        end
        load_step = (i_in.corr_offset > STEP_LIMIT) ? STEP_LIMIT : i_in.corr_offset;
    end

    whc_rank u_rank (
        .i_word    (r_w1),
        .i_pattern (r_hdr),
        .i_limit   (r_max),
        .o_rank    (rank)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in.func == FUNC_CORR && count != '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_UPD;
            ST_UPD:  n_state = acc_wrap ? ST_UPD2 : ST_EMIT;
            ST_UPD2: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = is_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = {cur, p_cur};
        mem_ra = {cur, p_cur};
        case (r_state)
            ST_UPD: begin
                mem_we = 1'b1;
                mem_ra = {cur, p_wrap};
            end
            ST_UPD2: mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= new_word;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hdr       <= RST_HEADER_PATTERN;
            r_max       <= RST_MAX_MISMATCHES;
            r_act       <= RST_ACTIVE_LOCATIONS;
            r_out_valid <= 1'b0;
            r_loc       <= '0;
            for (int i = 0; i < MAX_LOCATIONS; i++) begin
                r_pos[i]  <= '0;
                r_acc[i]  <= '0;
                r_len[i]  <= RST_LEN;
                r_step[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (cfg_xfer) begin
                case (i_cfg_index)
                    CFG_HEADER_PATTERN:   r_hdr <= i_cfg_data;
                    CFG_MAX_MISMATCHES:   r_max <= i_cfg_data[MAXM_W-1:0];
                    CFG_ACTIVE_LOCATIONS: r_act <= i_cfg_data[ACT_W-1:0];
                    default: ;
                endcase
            end

            if (in_xfer) begin
                r_loc <= '0;
                if (i_in.func == FUNC_LOAD && load_ok) begin
                    r_len[load_loc]  <= load_len;
                    r_step[load_loc] <= load_step;
                    r_pos[load_loc]  <= '0;
                    r_acc[load_loc]  <= '0;
                end
            end

            case (r_state)
                ST_UPD: begin
                    r_fill[cur] <= fill_new;
                    r_pos[cur]  <= p_wrap;
                    r_acc[cur]  <= acc_wrap ? (acc_sum - CORR_INTERVAL) : acc_sum;
                end
                ST_UPD2: begin
                    r_fill[cur] <= fill_new;
                    r_pos[cur]  <= p_wrap;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_loc <= r_loc + 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_word <= i_in.corr_word;
        end
        if (r_state == ST_UPD) begin
            r_w1     <= new_word;
            r_prev_p <= p_cur;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out.loc_index <= r_loc[3:0];
            r_out.rank      <= rank;
            r_out.last      <= is_last;
        end
    end

endmodule
